[rtl/positional_list_table_macros.svh]
// Assertion shorthands shared by the list table RTL.
// Each one samples on the rising clock edge and is silenced while reset is asserted.
`ifndef POSITIONAL_LIST_TABLE_MACROS_SVH
`define POSITIONAL_LIST_TABLE_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define PLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pltab_pkg.sv]
package pltab_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // What every cell of the chain does in each cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ERASE  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [POS_W-1:0]   pos;
  } cell_cmd_t;

  typedef struct packed {
    func_e                      func;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                    status;
    logic [FIDX_W-1:0]          found_index;
    logic signed [VALUE_W-1:0]  data_out;
    logic [COUNT_W-1:0]         count;
  } rsp_t;

endpackage

[rtl/pltab_cell.sv]
module pltab_cell
  import pltab_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned INDEX      = 0
) (
  input  logic                         clk_i,
  input  cell_cmd_t                    cmd_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic signed [DATA_WIDTH-1:0] left_i,
  input  logic signed [DATA_WIDTH-1:0] right_i,
  output logic signed [DATA_WIDTH-1:0] data_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (IdxW > POS_W) ? IdxW : POS_W;
  localparam logic [CmpW-1:0] MyIdx = CmpW'(INDEX);

  logic signed [DATA_WIDTH-1:0] data_q, data_d;
  logic [CmpW-1:0]              pos;

  assign pos = CmpW'(cmd_i.pos);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      CELL_HOLD: begin
        data_d = data_q;
      end
      // open a gap at the position, take the left neighbour above it
      CELL_INSERT: begin
        if (MyIdx == pos) begin
          data_d = value_i;
        end else if (MyIdx > pos) begin
          data_d = left_i;
        end
      end
      // close the gap: take the right neighbour from the position up
      CELL_ERASE: begin
        if (MyIdx >= pos) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        data_d = right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/positional_list_table.sv]
// Insert and erase: result strobe in the cycle after the word is taken; busy stays low,
//   so a new word may be started in every cycle.
// Find and read: the cell chain rotates once round, one step per cell; the result shows
//   after the last step of the rotation, and the next start is taken in that same cycle.
// Reset (rst_ni low, asynchronous) empties the list and clears the strobe; the stored
//   words are not cleared. The receiver cannot stall: each result is valid one cycle.
`include "positional_list_table_macros.svh"

module positional_list_table
  import pltab_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [IdxW-1:0] LastStep = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic                          done_q, done_d;
  rsp_t                          rsp_q, rsp_d;
  logic [IdxW-1:0]               step_q, step_d;
  logic                          hit_q, hit_d;
  logic [IdxW-1:0]               found_q, found_d;
  logic signed [DATA_WIDTH-1:0]  data_q, data_d;
  logic signed [DATA_WIDTH-1:0]  key_q, key_d;
  logic [POS_W-1:0]              pos_q, pos_d;
  func_e                         func_q, func_d;

  logic                          accept;
  logic signed [DATA_WIDTH-1:0]  value_w;
  logic [PosW-1:0]               pos_w, cnt_w, scan_pos_w;
  logic                          ins_bad, ers_bad, full, ins_ok, ers_ok;
  logic                          match, hit_now;
  logic [IdxW-1:0]               found_now;
  logic signed [DATA_WIDTH-1:0]  head, data_now;
  cell_cmd_t                     cmd;
  logic signed [DATA_WIDTH-1:0]  cell_data [CAPACITY];

  // ---------------------------------------------------------------------------
  // Request decode. The word is narrowed or sign-extended to the stored width.
  // ---------------------------------------------------------------------------
  assign busy    = (state_q == ST_SCAN);
  assign accept  = start & ~busy;
  assign value_w = DATA_WIDTH'(req_i.value);
  assign pos_w   = PosW'(req_i.position);
  assign cnt_w   = PosW'(count_q);
  assign full    = (count_q == FullCount);
  // insert may land one past the last entry (append); erase and read may not
  assign ins_bad = (pos_w > cnt_w);
  assign ers_bad = (pos_w >= cnt_w);
  assign ins_ok  = accept && (req_i.func == FUNC_INSERT) && !ins_bad && !full;
  assign ers_ok  = accept && (req_i.func == FUNC_ERASE) && !ers_bad;

  // ---------------------------------------------------------------------------
  // Chain command, broadcast to every cell. While scanning the whole chain
  // rotates towards cell 0, so entry k sits in cell 0 at scan step k and the
  // list is back in order after CAPACITY steps.
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd.pos = req_i.position;
    if (busy) begin
      cmd.op = CELL_ROTATE;
    end else if (ins_ok) begin
      cmd.op = CELL_INSERT;
    end else if (ers_ok) begin
      cmd.op = CELL_ERASE;
    end else begin
      cmd.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    logic signed [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = value_w;
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end
    // the last cell wraps round to cell 0 for the rotation
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[0];
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end

    pltab_cell #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (value_w),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Scan: watch cell 0 as the chain goes round. Find keeps the first match
  // below the count; read keeps the word seen at the requested step.
  // ---------------------------------------------------------------------------
  assign head       = cell_data[0];
  assign scan_pos_w = PosW'(pos_q);
  assign match      = (head == key_q) && (CntW'(step_q) < count_q);
  assign hit_now    = hit_q | match;
  assign found_now  = hit_q ? found_q : step_q;
  assign data_now   = (PosW'(step_q) == scan_pos_w) ? head : data_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    step_d  = step_q;
    hit_d   = hit_q;
    found_d = found_q;
    data_d  = data_q;
    key_d   = key_q;
    pos_d   = pos_q;
    func_d  = func_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rsp_d.status      = STAT_OK;
          rsp_d.found_index = '0;
          rsp_d.data_out    = '0;
          unique case (req_i.func) inside
            FUNC_INSERT: begin
              done_d = 1'b1;
              if (ins_bad) begin
                rsp_d.status = STAT_BAD_POS;
              end else if (full) begin
                rsp_d.status = STAT_FULL;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            FUNC_ERASE: begin
              done_d = 1'b1;
              if (ers_bad) begin
                rsp_d.status = STAT_BAD_POS;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            FUNC_FIND, FUNC_READ: begin
              // hold the request and start the rotation
              state_d = ST_SCAN;
              step_d  = '0;
              hit_d   = 1'b0;
              found_d = '0;
              data_d  = '0;
              key_d   = value_w;
              pos_d   = req_i.position;
              func_d  = req_i.func;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
          rsp_d.count = COUNT_W'(count_d);
        end
      end
      ST_SCAN: begin
        hit_d   = hit_now;
        found_d = found_now;
        data_d  = data_now;
        step_d  = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d           = ST_IDLE;
          done_d            = 1'b1;
          rsp_d.count       = COUNT_W'(count_q);
          rsp_d.status      = STAT_OK;
          rsp_d.found_index = '0;
          rsp_d.data_out    = '0;
          if (func_q == FUNC_FIND) begin
            if (hit_now) begin
              rsp_d.found_index = FIDX_W'(found_now);
            end else begin
              rsp_d.status = STAT_NOT_FOUND;
            end
          end else if (scan_pos_w >= PosW'(count_q)) begin
            rsp_d.status = STAT_BAD_POS;
          end else begin
            rsp_d.data_out = VALUE_W'(data_now);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      step_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      step_q  <= step_d;
      hit_q   <= hit_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    found_q <= found_d;
    data_q  <= data_d;
    key_q   <= key_d;
    pos_q   <= pos_d;
    func_q  <= func_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PLT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FullCount, "count above capacity")
  `PLT_ASSERT_NEXT(a_insert_grows, ins_ok, count_q == $past(count_q) + 1'b1,
                   "insert did not grow the count")
  `PLT_ASSERT_NEXT(a_scan_ends, (state_q == ST_SCAN) && (step_q == LastStep),
                   done_q && (state_q == ST_IDLE), "scan did not end with a result")
  `PLT_ASSERT_NOW(a_no_strobe_in_scan, state_q == ST_SCAN, !done_q,
                  "result strobe while scanning")
  `PLT_ASSERT_NOW(a_busy_drop, $fell(busy), done_q, "busy fell without a result")

endmodule
